### src/gbht_pkg.sv
package gbht_pkg;

  // table geometry
  localparam int MAX_BOXES    = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int IDX_W        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W        = $clog2(MAX_BOXES + 1);
  localparam int HCNT_W       = $clog2(RESULT_LIMIT + 1);

  // field widths
  localparam int MODE_W      = 2;
  localparam int COORD_W     = 12;
  localparam int LABEL_W     = 8;
  localparam int NORM_W      = 17;
  localparam int HIT_IDX_W   = 5;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = NORM_W + COORD_W;
  localparam int FLOOR_W     = PROD_W - FRAC_W;
  localparam int CEIL_W      = FLOOR_W + 1;

  localparam logic [NORM_W-1:0] ONE_Q16 = NORM_W'(65536);

  // register reset values
  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = COORD_W'(1200);
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = COORD_W'(720);

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // scaled coordinate: integer pixel floor and ceiling of a q.16 value
  typedef struct packed {
    logic [FLOOR_W-1:0] flo;
    logic [CEIL_W-1:0]  cei;
  } gbht_coord_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] left;
  } gbht_box_t;

endpackage

### src/gbht_mul.sv
module gbht_mul
  import gbht_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [NORM_W-1:0]  a,
  input  logic [COORD_W-1:0] b,
  output gbht_coord_t        coord
);

  logic [PROD_W-1:0] prod_r;

  // one registered multiply per cycle while en is high, shared by x and y
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  // floor and ceiling in whole pixels
  assign coord.flo = prod_r[PROD_W-1:FRAC_W];
  assign coord.cei = {1'b0, prod_r[PROD_W-1:FRAC_W]} + CEIL_W'(|prod_r[FRAC_W-1:0]);

endmodule

### src/gaze_box_hit_test.sv
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser: mode; tdata: box bounds, label, gaze x/y
// out_     out  tvalid/tready      tuser: hit; tdata: hit_index, hit_label; tlast
// cfg_     in   cfg_we             cfg_addr selects frame_width / frame_height
//
// clear and append produce no beat
// a query makes two passes through the shared multiplier, one load, then
// one table entry per cycle from the box memory port while the scan is not stalled,
// then a flush state that hands over the final beat
// a full output register stalls the scan only when a new hit must push out a held one
// rst_n is synchronous; it empties the table and restores the frame size registers
module gaze_box_hit_test
  import gbht_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // [11:0] box_left, [23:12] box_right, [35:24] box_top, [47:36] box_bottom,
  // [55:48] box_label, [72:56] gaze_x_norm, [89:73] gaze_y_norm, rest zero
  input  logic [95:0]        in_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]  in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // [4:0] hit_index, [12:5] hit_label, rest zero
  output logic [15:0]        out_tdata,
  // [0] hit
  output logic               out_tuser,
  output logic               out_tlast,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [COORD_W-1:0] cfg_wdata
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULX  = 3'd1;
  localparam logic [2:0] ST_MULY  = 3'd2;
  localparam logic [2:0] ST_LDY   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [COORD_W-1:0] fw_r, fh_r;
  logic [NORM_W-1:0]  nx_r, ny_r;
  logic               y_neg_r;
  gbht_coord_t        gx_r, gy_r, mul_coord;

  gbht_box_t          box_mem [MAX_BOXES];
  gbht_box_t          rdata_r;
  gbht_box_t          in_box;
  logic [CNT_W-1:0]   box_count_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [CNT_W-1:0]   cmp_idx_r;
  logic               cmp_vld_r;

  logic               pend_vld_r;
  logic [CNT_W-1:0]   pend_idx_r;
  logic [LABEL_W-1:0] pend_label_r;
  logic [HCNT_W-1:0]  hit_cnt_r;

  logic               out_valid_r;
  logic               out_hit_r, out_last_r;
  logic [HIT_IDX_W-1:0] out_idx_r;
  logic [LABEL_W-1:0] out_label_r;

  logic [MODE_W-1:0]  in_mode;
  logic               in_acc;
  logic               mul_en;
  logic [NORM_W-1:0]  mul_a;
  logic [COORD_W-1:0] mul_b;
  logic               box_hit, out_free, stall, hit_take, limit_hit, scan_done;
  logic               push_pend, flush_done;

  // unpack the input beat
  assign in_mode          = in_tuser;
  assign in_box.left      = in_tdata[11:0];
  assign in_box.right     = in_tdata[23:12];
  assign in_box.top       = in_tdata[35:24];
  assign in_box.bottom    = in_tdata[47:36];
  assign in_box.label     = in_tdata[55:48];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // frame size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        default:          fw_r <= fw_r;
      endcase
    end
  end

  // shared multiplier: x in the first pass, inverted y in the second
  assign mul_en = (state_r == ST_MULX) || (state_r == ST_MULY);
  assign mul_a  = (state_r == ST_MULX) ? nx_r : (ONE_Q16 - ny_r);
  assign mul_b  = (state_r == ST_MULX) ? fw_r : fh_r;

  gbht_mul u_mul (
    .clk   (clk),
    .en    (mul_en),
    .a     (mul_a),
    .b     (mul_b),
    .coord (mul_coord)
  );

  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_QUERY) begin
      nx_r <= in_tdata[72:56];
      ny_r <= in_tdata[89:73];
    end
    if (state_r == ST_MULY) begin
      gx_r    <= mul_coord;
      // gaze past 1.0 gives a negative y that no box can hold,
      // except with a zero height, which pins y to zero
      y_neg_r <= (ny_r > ONE_Q16) && (fh_r != '0);
    end
    if (state_r == ST_LDY) begin
      gy_r <= mul_coord;
    end
  end

  // box table: append writes at the fill count, clear only resets the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_count_r <= '0;
    end else if (in_acc) begin
      if (in_mode == MODE_CLEAR) begin
        box_count_r <= '0;
      end else if (in_mode == MODE_APPEND && box_count_r < CNT_W'(MAX_BOXES)) begin
        box_count_r <= box_count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_APPEND && box_count_r < CNT_W'(MAX_BOXES)) begin
      box_mem[box_count_r[IDX_W-1:0]] <= in_box;
    end
  end

  // compare stage: inclusive bounds on the q.16 point, done in whole pixels
  // left <= x  <=>  left <= floor(x);  x <= right  <=>  ceil(x) <= right
  assign box_hit = cmp_vld_r && !y_neg_r
                && ({1'b0, rdata_r.left} <= gx_r.flo)
                && (gx_r.cei <= {2'b00, rdata_r.right})
                && ({1'b0, rdata_r.top} <= gy_r.flo)
                && (gy_r.cei <= {2'b00, rdata_r.bottom});

  assign out_free   = !out_valid_r || out_tready;
  // a hit is held back one step so that the final one can carry last
  assign stall      = box_hit && pend_vld_r && !out_free;
  assign hit_take   = (state_r == ST_SCAN) && box_hit && !stall;
  assign push_pend  = hit_take && pend_vld_r;
  assign limit_hit  = hit_take && (hit_cnt_r == HCNT_W'(RESULT_LIMIT - 1));
  assign scan_done  = !cmp_vld_r && (rd_idx_r >= box_count_r);
  assign flush_done = (state_r == ST_FLUSH) && out_free;

  // scan pointer and registered table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (state_r != ST_SCAN) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (!stall) begin
      if (limit_hit) begin
        cmp_vld_r <= 1'b0;
      end else begin
        cmp_vld_r <= (rd_idx_r < box_count_r);
        if (rd_idx_r < box_count_r) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && !stall) begin
      rdata_r   <= box_mem[rd_idx_r[IDX_W-1:0]];
      cmp_idx_r <= rd_idx_r;
    end
  end

  // held hit and hit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      hit_cnt_r  <= '0;
    end else if (in_acc) begin
      pend_vld_r <= 1'b0;
      hit_cnt_r  <= '0;
    end else if (hit_take) begin
      pend_vld_r <= 1'b1;
      hit_cnt_r  <= hit_cnt_r + HCNT_W'(1);
    end else if (flush_done) begin
      pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_take) begin
      pend_idx_r   <= cmp_idx_r;
      pend_label_r <= rdata_r.label;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_pend || flush_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend) begin
      out_hit_r   <= 1'b1;
      out_idx_r   <= HIT_IDX_W'(pend_idx_r);
      out_label_r <= pend_label_r;
      out_last_r  <= 1'b0;
    end else if (flush_done) begin
      // either the held final hit or the single no-hit beat
      out_hit_r   <= pend_vld_r;
      out_idx_r   <= pend_vld_r ? HIT_IDX_W'(pend_idx_r) : '0;
      out_label_r <= pend_vld_r ? pend_label_r : '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_label_r, out_idx_r};
  assign out_tuser  = out_hit_r;
  assign out_tlast  = out_last_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_mode == MODE_QUERY) state_nxt = ST_MULX;
      ST_MULX:  state_nxt = ST_MULY;
      ST_MULY:  state_nxt = ST_LDY;
      ST_LDY:   state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_done || limit_hit) state_nxt = ST_FLUSH;
      ST_FLUSH: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    box_count_r <= CNT_W'(MAX_BOXES))
    else $error("box count beyond table depth");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == ST_SCAN))
    else $error("compare stage busy outside scan");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("held hit left over after query");

  a_hit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r <= HCNT_W'(RESULT_LIMIT))
    else $error("too many hits counted");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    flush_done |=> (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("query ended without a final beat");

endmodule
